// ===== design/integer_field_formatter_core_assert.svh =====
// Assertion macros shared by the formatter checker.
`ifndef INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define IFMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// next-cycle implication
`define IFMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

// ===== design/ifmt_pkg.sv =====
// Types, codes and character helpers for the integer field formatter.
package ifmt_pkg;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_OCT  = 3'd2;
  localparam logic [2:0] OP_HEX  = 3'd3;
  localparam logic [2:0] OP_HEXU = 3'd4;
  localparam logic [2:0] OP_PTR  = 3'd5;
  localparam logic [2:0] OP_CHAR = 3'd6;
  localparam logic [2:0] OP_NONE = 3'd7;

  localparam logic [1:0] SZ_INT  = 2'd0;
  localparam logic [1:0] SZ_BYTE = 2'd1;
  localparam logic [1:0] SZ_HALF = 2'd2;
  localparam logic [1:0] SZ_WIDE = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;

  localparam logic [127:0] DIGITS_LO = "0123456789abcdef";
  localparam logic [127:0] DIGITS_UP = "0123456789ABCDEF";

  // enough for 64-bit decimal, 16 hex or 11 octal digits
  localparam int DIG_NIBS = 20;
  localparam int QDEPTH   = 2;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  size_mode;
    logic [63:0] raw_value;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        alternate_form;
    logic        zero_fill;
    logic [5:0]  field_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_item_t;

  // classified conversion handed from front to back
  typedef struct packed {
    logic [DIG_NIBS*4-1:0] digits;
    logic [4:0]            dlen;
    logic [1:0]            plen;
    logic [7:0]            pre_x;
    logic                  has_sign;
    logic [7:0]            sign_ch;
    logic [5:0]            pad;
    logic                  left;
    logic                  zero;
    logic                  upper;
    logic                  char_mode;
    logic [7:0]            ch;
  } job_t;

  typedef enum logic [1:0] {FR_IDLE, FR_CONV, FR_PUSH} fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LEAD, BK_SIGN, BK_PRE, BK_ZERO, BK_DIG, BK_TRAIL
  } bk_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (upper) c = DIGITS_UP[8*(15-int'(nib)) +: 8];
    else       c = DIGITS_LO[8*(15-int'(nib)) +: 8];
    return c;
  endfunction

endpackage

// ===== design/integer_field_formatter_core.sv =====
// Top level of the integer field formatter: front, job queue and back.
//
//   channel | direction | payload     | handshake
//   in      | input     | in_item_t   | in_valid / in_stall
//   out     | output    | out_item_t  | out_valid / out_stall
//
// Decimal requests pass through the front's BCD shift loop over all VALUE_BITS
// bits before the job is queued; other conversions go straight to the push state.
// The back loads a job from the queue, then emits one character per cycle
// while the output is not stalled.
// Synchronous reset clears all control state; no clearing pass is needed.
// Output stalls back up only the back end; the front keeps working until
// the two-entry queue fills.
module integer_field_formatter_core #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ifmt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ifmt_pkg::out_item_t out_item
);

  ifmt_pkg::job_t wr_job, rd_job;
  logic push, pop, full, empty;

  ifmt_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .job      (wr_job),
    .full     (full)
  );

  ifmt_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  ifmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== design/ifmt_front.sv =====
// Front end: accepts requests, converts decimal to BCD, builds the job.
module ifmt_front #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ifmt_pkg::in_item_t in_item,
  output logic              push,
  output ifmt_pkg::job_t    job,
  input  logic              full
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int BCD_W = ifmt_pkg::DIG_NIBS * 4;
  localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

  ifmt_pkg::fr_state_t state, state_next;
  ifmt_pkg::in_item_t  req;
  logic [VALUE_BITS-1:0] bin;
  logic [BCD_W-1:0]      bcd, adj;
  logic [CNT_W-1:0]      cnt;
  logic                  neg;

  logic [6:0]  sh;
  logic [63:0] sx, mk, mag;
  logic        nv;

  always_comb begin
    case (in_item.size_mode)
      ifmt_pkg::SZ_BYTE: sh = 7'd56;
      ifmt_pkg::SZ_HALF: sh = 7'd48;
      ifmt_pkg::SZ_WIDE: sh = 7'(64 - VALUE_BITS);
      default:           sh = 7'd32;
    endcase
    sx = 64'($signed(in_item.raw_value << sh) >>> sh);
    mk = {64{1'b1}} >> sh;
    if (in_item.op == ifmt_pkg::OP_SDEC) begin
      nv  = sx[63];
      mag = nv ? (64'd0 - sx) : sx;
    end else begin
      nv  = 1'b0;
      mag = in_item.raw_value & mk;
    end
  end

  // add-3 correction on every BCD digit
  always_comb begin
    for (int i = 0; i < ifmt_pkg::DIG_NIBS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ifmt_pkg::FR_IDLE: begin
        if (in_valid) begin
          if (in_item.op == ifmt_pkg::OP_SDEC || in_item.op == ifmt_pkg::OP_UDEC)
            state_next = ifmt_pkg::FR_CONV;
          else if (in_item.op != ifmt_pkg::OP_NONE)
            state_next = ifmt_pkg::FR_PUSH;
        end
      end
      ifmt_pkg::FR_CONV: begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) state_next = ifmt_pkg::FR_PUSH;
      end
      ifmt_pkg::FR_PUSH: begin
        if (!full) state_next = ifmt_pkg::FR_IDLE;
      end
      default: state_next = ifmt_pkg::FR_IDLE;
    endcase
  end

  logic [31:0] lo32;
  logic [32:0] o33;
  logic [63:0] ptr;
  logic [5:0]  w;
  logic [4:0]  body;
  logic [4:0]  dl;

  always_comb begin
    in_stall = (state != ifmt_pkg::FR_IDLE);
    push     = (state == ifmt_pkg::FR_PUSH) && !full;

    lo32 = req.raw_value[31:0];
    o33  = {1'b0, lo32};
    ptr  = req.raw_value & PTR_MASK;

    job = '0;
    case (req.op)
      ifmt_pkg::OP_SDEC, ifmt_pkg::OP_UDEC: job.digits = bcd;
      ifmt_pkg::OP_OCT: begin
        for (int i = 0; i < 11; i++) job.digits[4*i +: 4] = {1'b0, o33[3*i +: 3]};
      end
      ifmt_pkg::OP_HEX, ifmt_pkg::OP_HEXU: begin
        for (int i = 0; i < 8; i++) job.digits[4*i +: 4] = lo32[4*i +: 4];
      end
      ifmt_pkg::OP_PTR: begin
        for (int i = 0; i < 16; i++) job.digits[4*i +: 4] = ptr[4*i +: 4];
      end
      default: job.digits = '0;
    endcase

    dl = 5'd1;
    for (int i = 0; i < ifmt_pkg::DIG_NIBS; i++) begin
      if (job.digits[4*i +: 4] != 4'd0) dl = 5'(i + 1);
    end
    job.char_mode = (req.op == ifmt_pkg::OP_CHAR);
    job.ch        = req.raw_value[7:0];
    job.dlen      = job.char_mode ? 5'd1 : dl;
    job.upper     = (req.op == ifmt_pkg::OP_HEXU);
    job.pre_x     = job.upper ? ifmt_pkg::CH_XU : ifmt_pkg::CH_X;

    case (req.op)
      ifmt_pkg::OP_OCT:                     job.plen = (req.alternate_form && lo32 != 0) ? 2'd1 : 2'd0;
      ifmt_pkg::OP_HEX, ifmt_pkg::OP_HEXU:  job.plen = (req.alternate_form && lo32 != 0) ? 2'd2 : 2'd0;
      ifmt_pkg::OP_PTR:                     job.plen = 2'd2;
      default:                              job.plen = 2'd0;
    endcase

    job.has_sign = neg || req.force_plus || req.space_sign;
    if (neg)                 job.sign_ch = ifmt_pkg::CH_MINUS;
    else if (req.force_plus) job.sign_ch = ifmt_pkg::CH_PLUS;
    else                     job.sign_ch = ifmt_pkg::CH_SPACE;

    w    = (req.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req.field_width;
    body = {3'b0, job.plen} + job.dlen;
    job.pad = (w > {1'b0, body}) ? (w - {1'b0, body} - {5'b0, job.has_sign}) : 6'd0;
    job.left = req.left_justify;
    job.zero = req.zero_fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifmt_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ifmt_pkg::FR_IDLE && in_valid) begin
      req <= in_item;
      bin <= mag[VALUE_BITS-1:0];
      bcd <= '0;
      cnt <= '0;
      neg <= nv;
    end else if (state == ifmt_pkg::FR_CONV) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      bin <= bin << 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== design/ifmt_fifo.sv =====
// Two-entry job queue between front and back.
module ifmt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ifmt_pkg::job_t wr_job,
  input  logic           pop,
  output ifmt_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(ifmt_pkg::QDEPTH);

  ifmt_pkg::job_t mem [ifmt_pkg::QDEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W:0]   count;

  assign full   = (count == (PTR_W+1)'(ifmt_pkg::QDEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_job;
  end

endmodule

// ===== design/ifmt_back.sv =====
// Back end: walks the field segments and emits one character per cycle while the output is not stalled.
module ifmt_back (
  input  logic                clk,
  input  logic                rst,
  input  ifmt_pkg::job_t      job,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ifmt_pkg::out_item_t out_item
);

  ifmt_pkg::bk_state_t state, state_next;
  ifmt_pkg::job_t      jb;
  logic [5:0]          cnt;

  function automatic logic [5:0] seg_len(input ifmt_pkg::bk_state_t s,
                                         input ifmt_pkg::job_t j);
    logic [5:0] n;
    case (s)
      ifmt_pkg::BK_LEAD:  n = (!j.left && !j.zero) ? j.pad : 6'd0;
      ifmt_pkg::BK_SIGN:  n = {5'b0, j.has_sign};
      ifmt_pkg::BK_PRE:   n = {4'b0, j.plen};
      ifmt_pkg::BK_ZERO:  n = (!j.left && j.zero) ? j.pad : 6'd0;
      ifmt_pkg::BK_DIG:   n = {1'b0, j.dlen};
      ifmt_pkg::BK_TRAIL: n = j.left ? j.pad : 6'd0;
      default:            n = 6'd0;
    endcase
    return n;
  endfunction

  // next non-empty segment after s, idle when none is left
  function automatic ifmt_pkg::bk_state_t seg_after(input ifmt_pkg::bk_state_t s,
                                                    input ifmt_pkg::job_t j);
    ifmt_pkg::bk_state_t r;
    ifmt_pkg::bk_state_t k;
    r = ifmt_pkg::BK_IDLE;
    for (int i = 6; i >= 1; i--) begin
      k = ifmt_pkg::bk_state_t'(3'(i));
      if (k > s && seg_len(k, j) != 6'd0) r = k;
    end
    return r;
  endfunction

  logic                adv, seg_end;
  logic [5:0]          len;
  ifmt_pkg::bk_state_t after;
  logic [4:0]          didx;
  logic [7:0]          ch;

  always_comb begin
    len     = seg_len(state, jb);
    after   = seg_after(state, jb);
    seg_end = (cnt == len - 6'd1);
    adv     = (state != ifmt_pkg::BK_IDLE) && (!out_valid || !out_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ifmt_pkg::BK_IDLE: begin
        if (!empty) state_next = seg_after(ifmt_pkg::BK_IDLE, job);
      end
      ifmt_pkg::BK_LEAD, ifmt_pkg::BK_SIGN, ifmt_pkg::BK_PRE, ifmt_pkg::BK_ZERO,
      ifmt_pkg::BK_DIG, ifmt_pkg::BK_TRAIL: begin
        if (adv && seg_end) state_next = after;
      end
      default: state_next = ifmt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == ifmt_pkg::BK_IDLE) && !empty;
    didx = jb.dlen - 5'd1 - cnt[4:0];
    unique case (state)
      ifmt_pkg::BK_LEAD:  ch = ifmt_pkg::CH_SPACE;
      ifmt_pkg::BK_SIGN:  ch = jb.sign_ch;
      ifmt_pkg::BK_PRE:   ch = (cnt == 6'd0) ? ifmt_pkg::CH_ZERO : jb.pre_x;
      ifmt_pkg::BK_ZERO:  ch = ifmt_pkg::CH_ZERO;
      ifmt_pkg::BK_DIG:   ch = jb.char_mode ? jb.ch
                               : ifmt_pkg::hex_char(jb.digits[4*didx +: 4], jb.upper);
      ifmt_pkg::BK_TRAIL: ch = ifmt_pkg::CH_SPACE;
      default:            ch = ifmt_pkg::CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ifmt_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv)             out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      jb  <= job;
      cnt <= 6'd0;
    end else if (adv) begin
      cnt <= seg_end ? 6'd0 : cnt + 6'd1;
    end
    if (adv) begin
      out_item.char_out  <= ch;
      out_item.last_char <= seg_end && (after == ifmt_pkg::BK_IDLE);
    end
  end

endmodule

// ===== design/ifmt_chk.sv =====
// Port-level checker for the formatter and its bind.
`include "integer_field_formatter_core_assert.svh"

module ifmt_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input ifmt_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input ifmt_pkg::out_item_t out_item
);

  // a real conversion keeps the front busy on the next cycle
  `IFMT_ASSERT_NEXT(a_front_busy, in_valid && !in_stall && in_item.op != ifmt_pkg::OP_NONE, in_stall)
  `IFMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `IFMT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))

endmodule

bind integer_field_formatter_core ifmt_chk u_chk (.*);

// ===== tb/tb_integer_field_formatter_core.sv =====
// Testbench for the integer field formatter: directed and random requests, self-checked.
`timescale 1ns / 100ps

class char_scoreboard;
  ifmt_pkg::out_item_t pending_chars[$];
  int errors;
  int items_noted;
  int chars_checked;

  function new();
    errors = 0;
    items_noted = 0;
    chars_checked = 0;
  endfunction

  // Append the digit string of v in the given base, most significant first.
  static function void append_digits(input logic [63:0] v, input int base, input bit upper,
                                     ref byte unsigned dig[$]);
    byte unsigned tmp[$];
    int d;
    tmp = {};
    do begin
      d = int'(v % base);
      if (d < 10) tmp.push_front(8'(8'h30 + d));
      else if (upper) tmp.push_front(8'(8'h41 + d - 10));
      else tmp.push_front(8'(8'h61 + d - 10));
      v = v / base;
    end while (v != 0);
    foreach (tmp[i]) dig.push_back(tmp[i]);
  endfunction

  // Build the characters one request produces and queue them.
  function void note_request(input ifmt_pkg::in_item_t it);
    byte unsigned pre[$];
    byte unsigned dig[$];
    byte unsigned seq[$];
    byte unsigned sign_ch;
    logic [63:0] v;
    int sbits;
    int pad;
    int body;
    int n;
    bit has_sign;
    bit neg;
    ifmt_pkg::out_item_t o;
    pre = {};
    dig = {};
    seq = {};
    neg = 0;
    items_noted++;
    case (it.size_mode)
      ifmt_pkg::SZ_BYTE: sbits = 8;
      ifmt_pkg::SZ_HALF: sbits = 16;
      ifmt_pkg::SZ_WIDE: sbits = 64;
      default: sbits = 32;
    endcase
    case (it.op)
      ifmt_pkg::OP_SDEC: begin
        v = it.raw_value;
        if (sbits < 64) begin
          v = v & ((64'd1 << sbits) - 1);
          if (v[sbits-1]) v = v | ~((64'd1 << sbits) - 1);
        end
        if (v[63]) begin
          neg = 1;
          v = 64'd0 - v;
        end
        append_digits(v, 10, 0, dig);
      end
      ifmt_pkg::OP_UDEC: begin
        v = it.raw_value;
        if (sbits < 64) v = v & ((64'd1 << sbits) - 1);
        append_digits(v, 10, 0, dig);
      end
      ifmt_pkg::OP_OCT: begin
        v = {32'd0, it.raw_value[31:0]};
        append_digits(v, 8, 0, dig);
        if (it.alternate_form && v != 0) pre.push_back(ifmt_pkg::CH_ZERO);
      end
      ifmt_pkg::OP_HEX, ifmt_pkg::OP_HEXU: begin
        v = {32'd0, it.raw_value[31:0]};
        append_digits(v, 16, it.op == ifmt_pkg::OP_HEXU, dig);
        if (it.alternate_form && v != 0) begin
          pre.push_back(ifmt_pkg::CH_ZERO);
          pre.push_back(it.op == ifmt_pkg::OP_HEXU ? ifmt_pkg::CH_XU : ifmt_pkg::CH_X);
        end
      end
      ifmt_pkg::OP_PTR: begin
        pre.push_back(ifmt_pkg::CH_ZERO);
        pre.push_back(ifmt_pkg::CH_X);
        append_digits(it.raw_value, 16, 0, dig);
      end
      ifmt_pkg::OP_CHAR: dig.push_back(it.raw_value[7:0]);
      default: return;
    endcase
    has_sign = 1;
    if (neg) sign_ch = ifmt_pkg::CH_MINUS;
    else if (it.force_plus) sign_ch = ifmt_pkg::CH_PLUS;
    else if (it.space_sign) sign_ch = ifmt_pkg::CH_SPACE;
    else has_sign = 0;
    body = pre.size() + dig.size();
    pad = 0;
    if (int'(it.field_width) > body) begin
      pad = int'(it.field_width) - body;
      if (has_sign) pad--;
    end
    if (!it.left_justify && !it.zero_fill)
      for (int i = 0; i < pad; i++) seq.push_back(ifmt_pkg::CH_SPACE);
    if (has_sign) seq.push_back(sign_ch);
    foreach (pre[i]) seq.push_back(pre[i]);
    if (!it.left_justify && it.zero_fill)
      for (int i = 0; i < pad; i++) seq.push_back(ifmt_pkg::CH_ZERO);
    foreach (dig[i]) seq.push_back(dig[i]);
    if (it.left_justify)
      for (int i = 0; i < pad; i++) seq.push_back(ifmt_pkg::CH_SPACE);
    n = (seq.size() > 64) ? 64 : seq.size();
    for (int i = 0; i < n; i++) begin
      o.char_out = seq[i];
      o.last_char = (i == n - 1);
      pending_chars.push_back(o);
    end
  endfunction

  task report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at char %0d: %s got %0h want %0h", chars_checked, what, got, want);
  endtask

  task check_char(input ifmt_pkg::out_item_t got);
    ifmt_pkg::out_item_t want;
    if (pending_chars.size() == 0) begin
      report("unexpected char_out", got.char_out, 0);
      return;
    end
    want = pending_chars.pop_front();
    if (got.char_out !== want.char_out) report("char_out", got.char_out, want.char_out);
    if (got.last_char !== want.last_char) report("last_char", got.last_char, want.last_char);
    chars_checked++;
  endtask
endclass

module tb_integer_field_formatter_core;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  ifmt_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  ifmt_pkg::out_item_t out_item;
  char_scoreboard sb;
  int cycles;
  bit hold_off;

  integer_field_formatter_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one request and hold it until accepted.
  task automatic send_request(input ifmt_pkg::in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
  endtask

  task automatic go_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic ifmt_pkg::in_item_t rand_request();
    ifmt_pkg::in_item_t it;
    it = '0;
    it.op = 3'($urandom_range(7, 0));
    it.size_mode = 2'($urandom_range(3, 0));
    case ($urandom_range(3, 0))
      0: it.raw_value = {$urandom, $urandom};
      1: it.raw_value = 64'($urandom_range(20, 0));
      2: it.raw_value = {{32{1'b1}}, $urandom};
      default: it.raw_value = {32'd0, $urandom};
    endcase
    {it.left_justify, it.force_plus, it.space_sign, it.alternate_form, it.zero_fill}
      = 5'($urandom_range(31, 0));
    // mostly short fields, some wide
    it.field_width = ($urandom_range(9, 0) == 0) ? 6'($urandom_range(63, 40))
                                                 : 6'($urandom_range(16, 0));
    return it;
  endfunction

  function automatic ifmt_pkg::in_item_t make_request(input logic [2:0] op,
                                                      input logic [1:0] sz,
                                                      input logic [63:0] v,
                                                      input logic [4:0] flags,
                                                      input logic [5:0] w);
    ifmt_pkg::in_item_t it;
    it.op = op;
    it.size_mode = sz;
    it.raw_value = v;
    {it.left_justify, it.force_plus, it.space_sign, it.alternate_form, it.zero_fill} = flags;
    it.field_width = w;
    return it;
  endfunction

  // receiver: own stall pattern, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      case (cycles % 300 < 100)
        1'b1: out_stall <= 1'b0;
        default: out_stall <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_char(out_item);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[integer_field_formatter_core] ERROR");
      $finish;
    end
  end

  // long output hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (sb != null && sb.items_noted >= 40);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int burst;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_WIDE,
                              64'h8000_0000_0000_0000, 5'b00000, 6'd0));
    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_INT,
                              64'hFFFF_FFFF, 5'b00001, 6'd8));
    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_BYTE,
                              64'h80, 5'b01000, 6'd6));
    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_HALF,
                              64'h7FFF, 5'b00100, 6'd9));
    send_request(make_request(ifmt_pkg::OP_UDEC, ifmt_pkg::SZ_WIDE,
                              {64{1'b1}}, 5'b00000, 6'd63));
    send_request(make_request(ifmt_pkg::OP_UDEC, ifmt_pkg::SZ_BYTE,
                              64'h1FF, 5'b10000, 6'd5));
    send_request(make_request(ifmt_pkg::OP_UDEC, ifmt_pkg::SZ_INT,
                              64'd0, 5'b01001, 6'd3));
    send_request(make_request(ifmt_pkg::OP_OCT, ifmt_pkg::SZ_INT,
                              64'hFFFF_FFFF_FFFF_FFFF, 5'b00010, 6'd14));
    send_request(make_request(ifmt_pkg::OP_OCT, ifmt_pkg::SZ_INT,
                              64'd0, 5'b00010, 6'd2));
    send_request(make_request(ifmt_pkg::OP_HEX, ifmt_pkg::SZ_INT,
                              64'h1_DEAD_BEEF, 5'b00011, 6'd12));
    send_request(make_request(ifmt_pkg::OP_HEXU, ifmt_pkg::SZ_INT,
                              64'hDEAD_BEEF, 5'b10110, 6'd14));
    send_request(make_request(ifmt_pkg::OP_HEXU, ifmt_pkg::SZ_INT,
                              64'd0, 5'b00010, 6'd0));
    send_request(make_request(ifmt_pkg::OP_PTR, ifmt_pkg::SZ_INT,
                              {64{1'b1}}, 5'b01000, 6'd20));
    send_request(make_request(ifmt_pkg::OP_PTR, ifmt_pkg::SZ_INT,
                              64'd0, 5'b00001, 6'd6));
    send_request(make_request(ifmt_pkg::OP_CHAR, ifmt_pkg::SZ_INT,
                              64'h100, 5'b00001, 6'd4));
    send_request(make_request(ifmt_pkg::OP_CHAR, ifmt_pkg::SZ_INT,
                              64'hFF, 5'b10100, 6'd3));
    send_request(make_request(ifmt_pkg::OP_NONE, ifmt_pkg::SZ_INT,
                              64'h55, 5'b11111, 6'd63));
    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_INT,
                              64'h5, 5'b11101, 6'd63));
    send_request(make_request(ifmt_pkg::OP_SDEC, ifmt_pkg::SZ_WIDE,
                              64'hAAAA_5555_AAAA_5555, 5'b00000, 6'd1));

    for (int i = 0; i < 241; i += burst) begin
      burst = $urandom_range(12, 1);
      for (int j = 0; j < burst; j++) send_request(rand_request());
      if ($urandom_range(1, 0)) go_idle($urandom_range(30, 1));
    end
    in_valid <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d requests formatted, %0d characters checked", sb.items_noted,
             sb.chars_checked);
    $display("all conversions, sizes and flags, short and wide fields, long output hold-off");
    if (sb.errors == 0 && sb.pending_chars.size() == 0)
      $display("[integer_field_formatter_core] OK");
    else
      $display("[integer_field_formatter_core] ERROR");
    $finish;
  end
endmodule
